// ===== hw/rtl/isqrt_pkg.sv =====
`default_nettype none

package isqrt_pkg;

  localparam int RADICAND_BITS_DEF = 31;

endpackage

`default_nettype wire

// ===== hw/rtl/isqrt_stage.sv =====
`default_nettype none

module isqrt_stage #(
  parameter int ROOT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  input  wire logic                       in_valid,
  input  wire logic [2*ROOT_BITS-1:0]     in_rad,
  input  wire logic [ROOT_BITS-1:0]       in_q,
  input  wire logic [ROOT_BITS+1:0]       in_rem,
  output logic                            out_valid,
  output logic [2*ROOT_BITS-1:0]          out_rad,
  output logic [ROOT_BITS-1:0]            out_q,
  output logic [ROOT_BITS+1:0]            out_rem
);

  localparam int RAD_W  = 2 * ROOT_BITS;
  localparam int REM_W  = ROOT_BITS + 2;
  localparam int WIDE_W = ROOT_BITS + 4;

  logic                 valid_r;
  logic [RAD_W-1:0]     rad_r, rad_nxt;
  logic [ROOT_BITS-1:0] q_r, q_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [WIDE_W-1:0]    rem_ext;
  logic [WIDE_W-1:0]    trial;
  logic [WIDE_W-1:0]    diff;

  // bring down the next two radicand bits, try (q << 2) | 1
  always_comb begin
    rem_ext = {in_rem, in_rad[RAD_W-1 -: 2]};
    trial   = WIDE_W'({in_q, 2'b01});
    diff    = rem_ext - trial;
    rad_nxt = {in_rad[RAD_W-3:0], 2'b00};
    if (rem_ext >= trial) begin
      rem_nxt = diff[REM_W-1:0];
      q_nxt   = {in_q[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = rem_ext[REM_W-1:0];
      q_nxt   = {in_q[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rad_r <= rad_nxt;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_q     = q_r;
  assign out_rem   = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_square_root.sv =====
// Integer square root, floor. Each item on in_tdata carries an unsigned radicand;
// out_tdata returns floor(sqrt(radicand)). The datapath is a pipeline of
// (RADICAND_BITS + 1) / 2 stages, one root bit per stage (16 for the default
// 31-bit radicand), and a new item can enter every cycle unless the pipeline
// is held. The whole pipeline holds while the result in the last stage waits
// for out_tready; bubbles travel as cleared valid bits.
`default_nettype none

module integer_square_root #(
  parameter int RADICAND_BITS = isqrt_pkg::RADICAND_BITS_DEF,
  localparam int ROOT_BITS    = (RADICAND_BITS + 1) / 2,
  localparam int IN_W         = ((RADICAND_BITS + 7) / 8) * 8,
  localparam int OUT_W        = ((ROOT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // radicand
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // root
);

  localparam int RAD_W = 2 * ROOT_BITS;
  localparam int REM_W = ROOT_BITS + 2;

  logic                 advance;
  logic                 valid_c [ROOT_BITS+1];
  logic [RAD_W-1:0]     rad_c   [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] q_c     [ROOT_BITS+1];
  logic [REM_W-1:0]     rem_c   [ROOT_BITS+1];

  assign advance   = !valid_c[ROOT_BITS] || out_tready;
  assign in_tready = advance;

  assign valid_c[0] = in_tvalid;
  assign rad_c[0]   = RAD_W'(in_tdata[RADICAND_BITS-1:0]);
  assign q_c[0]     = '0;
  assign rem_c[0]   = '0;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
    isqrt_stage #(
      .ROOT_BITS(ROOT_BITS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .in_valid (valid_c[i]),
      .in_rad   (rad_c[i]),
      .in_q     (q_c[i]),
      .in_rem   (rem_c[i]),
      .out_valid(valid_c[i+1]),
      .out_rad  (rad_c[i+1]),
      .out_q    (q_c[i+1]),
      .out_rem  (rem_c[i+1])
    );
  end

  assign out_tvalid = valid_c[ROOT_BITS];
  assign out_tdata  = OUT_W'(q_c[ROOT_BITS]);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

class root_scoreboard;
  typedef struct {
    bit [30:0] radicand;
    bit [15:0] root;
  } root_entry_t;

  root_entry_t expected_roots[$];
  int errors = 0;
  int checked = 0;

  // floor(sqrt(r)), one root bit per pass, 64-bit so nothing overflows
  function automatic bit [15:0] floor_root(bit [30:0] r);
    longint unsigned rem;
    longint unsigned acc;
    longint unsigned probe;
    rem = r;
    acc = 0;
    probe = 64'h1 << 30;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= acc + probe) begin
        rem = rem - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return acc[15:0];
  endfunction

  function void note_radicand(bit [30:0] r);
    root_entry_t e;
    e.radicand = r;
    e.root = floor_root(r);
    expected_roots.push_back(e);
  endfunction

  function void check_root(logic [15:0] got);
    root_entry_t e;
    if (expected_roots.size() == 0) begin
      errors++;
      if (errors <= 10) $display("tb_top: unexpected root item %0h", got);
      return;
    end
    e = expected_roots.pop_front();
    checked++;
    if (got !== e.root) begin
      errors++;
      if (errors <= 10)
        $display("tb_top: radicand %0d root expected %0d got %0d", e.radicand, e.root, got);
    end
  endfunction

  function int pending();
    return expected_roots.size();
  endfunction
endclass

module tb_top;
  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [30:0] radicand, [31] pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] root
  logic        hold_off = 1'b0;

  root_scoreboard sb = new();
  int sent_cnt = 0;
  int burst_left = 0;

  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_CYCLES  = 200;

  integer_square_root dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic send_radicand(input logic [31:0] word);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_radicand(word[30:0]);
    sent_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  function automatic logic [31:0] random_radicand();
    int unsigned k;
    int unsigned w;
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: begin
        w = $urandom_range(1, 31);
        v = $urandom & ((32'h1 << w) - 1);
      end
      2: begin
        k = $urandom_range(0, 46340);
        v = k * k;
      end
      3: begin
        k = $urandom_range(1, 46340);
        v = k * k - 1;
      end
      4: begin
        k = $urandom_range(0, 46339);
        v = k * k + $urandom_range(0, 2 * k);
      end
      default: v = $urandom_range(0, 1023);
    endcase
    v[31] = ($urandom_range(0, 15) == 0);
    return v;
  endfunction

  // output side: the stall pattern switches among four randomly chosen modes
  initial begin
    int mode;
    int left;
    bit rdy;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_root(out_tdata);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (left % 5 != 0);
      endcase
      out_tready <= rdy && !hold_off;
    end
  end

  // long output stall so the pipeline fills and backs up the input
  initial begin
    wait (sent_cnt >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [31:0] corner_words[];
    corner_words = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16, 32'd24, 32'd25,
      32'd99, 32'd100, 32'd65535, 32'd65536, 32'h4000_0000, 32'h7FFF_FFFF,
      32'd2147395600, 32'd2147395599, 32'd2147302921, 32'h5555_5555, 32'h2AAA_AAAA,
      32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0019
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 40);
    foreach (corner_words[i]) send_radicand(corner_words[i]);
    repeat (RANDOM_ITEMS) send_radicand(random_radicand());
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("tb_top: %0d radicands sent, %0d roots compared", sent_cnt, sb.checked);
    $display("tb_top: covered range ends, exact squares and neighbors, a long output stall");
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches", sb.errors);
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
